// ===== design/hpm_pkg.sv =====
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types, constants and fp32 / bf16 helper functions of the
// hyper-connection post mix block.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam int STREAM_COUNT = 4;
  localparam int COEF_COUNT   = STREAM_COUNT + STREAM_COUNT * STREAM_COUNT;
  localparam int MUL_STAGES   = 3;
  localparam int ADD_STAGES   = 4;
  localparam int LATENCY      = MUL_STAGES + STREAM_COUNT * ADD_STAGES + 1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  coef_index;
    logic [31:0] coef_value;
    logic [15:0] layer_value;
    logic [15:0] residual_0;
    logic [15:0] residual_1;
    logic [15:0] residual_2;
    logic [15:0] residual_3;
    logic        last_column;
  } hpm_in_t;

  typedef struct packed {
    logic [15:0] out_0;
    logic [15:0] out_1;
    logic [15:0] out_2;
    logic [15:0] out_3;
    logic        end_of_token;
    logic        nonfinite_error;
  } hpm_out_t;

  // side info that rides along with each column request
  typedef struct packed {
    logic last;
    logic err;
  } hpm_tag_t;

  // leading zero count of a 32-bit word (zero word gives 0)
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // round to nearest even and pack; sig[25] is the leading one at biased
  // exponent e, sig[1] the guard bit, sig[0] the sticky bit
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [10:0] e,
                                             input logic [25:0] sig);
    logic [25:0] s2;
    logic [25:0] lost;
    logic [10:0] sh;
    logic [7:0]  eb;
    logic        rnd;
    logic [30:0] mag;
    logic [31:0] res;
    s2   = sig;
    lost = '0;
    sh   = '0;
    eb   = 8'd0;
    // subnormal range: shift right, folding lost bits into sticky
    if (e <= 11'sd0) begin
      sh = 11'(11'sd1 - e);
      if (sh >= 11'd26) begin
        s2 = {25'b0, |sig};
      end else begin
        lost = sig & ((26'd1 << sh[4:0]) - 26'd1);
        s2   = (sig >> sh[4:0]) | {25'b0, |lost};
      end
    end else begin
      eb = e[7:0] - 8'd1;
    end
    rnd = s2[1] & (s2[0] | s2[2]);
    // hidden bit and rounding carry propagate into the exponent field
    mag = {eb, 23'b0} + {7'b0, s2[25:2]} + {30'b0, rnd};
    if (sig == 26'd0) begin
      res = {sgn, 31'b0};
    end else if (e >= 11'sd255) begin
      res = {sgn, 8'hFF, 23'b0};
    end else begin
      res = {sgn, mag};
    end
    return res;
  endfunction

  // fp32 to bf16, nearest even, any nan becomes the quiet nan
  function automatic logic [15:0] to_bf16(input logic [31:0] x);
    logic [31:0] t;
    t = x + 32'h0000_7FFF + {31'b0, x[16]};
    if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return BF16_QNAN;
    return t[31:16];
  endfunction

  function automatic logic bf16_finite(input logic [15:0] v);
    return v[14:7] != 8'hFF;
  endfunction

  function automatic logic fp32_finite(input logic [31:0] v);
    return v[30:23] != 8'hFF;
  endfunction

endpackage

// ===== design/hpm_fmul.sv =====
// ----------------------------------------------------------------------------
// hpm_fmul
// Pipelined fp32 by bf16 multiplier, finite operands, fp32 result rounded
// to nearest even; three register stages.
// ----------------------------------------------------------------------------
module hpm_fmul
  import hpm_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [15:0] b,
  output logic [31:0] y
);

  logic [23:0]        ma;
  logic [7:0]         mb;
  logic [7:0]         ea;
  logic [7:0]         eb;
  logic [31:0]        p_nxt;
  logic signed [10:0] esum_nxt;
  logic [31:0]        p_r;
  logic               s1_r;
  logic signed [10:0] esum_r;

  logic [4:0]         lz;
  logic [31:0]        norm;
  logic [25:0]        sig_nxt;
  logic signed [10:0] e2_nxt;
  logic [25:0]        sig_r;
  logic signed [10:0] e2_r;
  logic               s2_r;
  logic [31:0]        y_r;

  // stage 1: unpack and integer product
  always_comb begin
    ma       = {a[30:23] != 8'd0, a[22:0]};
    mb       = {b[14:7] != 8'd0, b[6:0]};
    ea       = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb       = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
    p_nxt    = 32'(ma) * 32'(mb);
    esum_nxt = 11'(ea) + 11'(eb) - 11'd126;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      s1_r   <= a[31] ^ b[15];
      esum_r <= esum_nxt;
    end
  end

  // stage 2: normalize so the leading one sits at the top
  always_comb begin
    lz      = lzc32(p_r);
    norm    = p_r << lz;
    sig_nxt = {norm[31:7], |norm[6:0]};
    e2_nxt  = esum_r - 11'(lz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sig_r <= sig_nxt;
      e2_r  <= e2_nxt;
      s2_r  <= s1_r;
    end
  end

  // stage 3: round and pack
  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= round_pack(s2_r, e2_r, sig_r);
    end
  end

  assign y = y_r;

endmodule

// ===== design/hpm_fadd.sv =====
// ----------------------------------------------------------------------------
// hpm_fadd
// Pipelined fp32 adder, round to nearest even, full special value handling;
// four register stages: align, add, normalize, round.
// ----------------------------------------------------------------------------
module hpm_fadd
  import hpm_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        nan_a, nan_b, inf_a, inf_b;
  logic        spec_nxt;
  logic [31:0] spec_val_nxt;
  logic        a_big;
  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, d;
  logic [23:0] m_big, m_sml;
  logic [26:0] ms27, lost, ms_al;

  logic        spec1_r, sub1_r, sgn1_r, zs1_r;
  logic [31:0] sval1_r;
  logic [7:0]  e1_r;
  logic [26:0] mb1_r, ms1_r;

  logic        spec2_r, sgn2_r, zs2_r;
  logic [31:0] sval2_r;
  logic [7:0]  e2_r;
  logic [27:0] sum2_r;

  logic [4:0]         lz;
  logic [27:0]        norm;
  logic               spec3_r, sgn3_r;
  logic [31:0]        sval3_r;
  logic signed [10:0] e3_r;
  logic [25:0]        sig3_r;
  logic [31:0]        y_r;

  // stage 1: special values, order by magnitude, align the smaller operand
  always_comb begin
    nan_a    = a[30:23] == 8'hFF && a[22:0] != 23'd0;
    nan_b    = b[30:23] == 8'hFF && b[22:0] != 23'd0;
    inf_a    = a[30:23] == 8'hFF && a[22:0] == 23'd0;
    inf_b    = b[30:23] == 8'hFF && b[22:0] == 23'd0;
    spec_nxt = nan_a | nan_b | inf_a | inf_b;
    if (nan_a || nan_b || (inf_a && inf_b && a[31] != b[31])) begin
      spec_val_nxt = FP32_QNAN;
    end else if (inf_a) begin
      spec_val_nxt = a;
    end else begin
      spec_val_nxt = b;
    end
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    m_big = {big[30:23] != 8'd0, big[22:0]};
    m_sml = {sml[30:23] != 8'd0, sml[22:0]};
    d     = e_big - e_sml;
    ms27  = {m_sml, 3'b0};
    lost  = '0;
    if (d >= 8'd27) begin
      ms_al = {26'b0, |m_sml};
    end else begin
      lost  = ms27 & ((27'd1 << d[4:0]) - 27'd1);
      ms_al = (ms27 >> d[4:0]) | {26'b0, |lost};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r <= spec_nxt;
      sval1_r <= spec_val_nxt;
      sub1_r  <= big[31] ^ sml[31];
      sgn1_r  <= big[31];
      zs1_r   <= big[31] & sml[31];
      e1_r    <= e_big;
      mb1_r   <= {m_big, 3'b0};
      ms1_r   <= ms_al;
    end
  end

  // stage 2: magnitude add or subtract
  always_ff @(posedge clk) begin
    if (en) begin
      spec2_r <= spec1_r;
      sval2_r <= sval1_r;
      sgn2_r  <= sgn1_r;
      zs2_r   <= zs1_r;
      e2_r    <= e1_r;
      sum2_r  <= sub1_r ? ({1'b0, mb1_r} - {1'b0, ms1_r})
                        : ({1'b0, mb1_r} + {1'b0, ms1_r});
    end
  end

  // stage 3: normalize, exact zero takes its sign from both operands
  always_comb begin
    lz   = lzc32({sum2_r, 4'b0});
    norm = sum2_r << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec3_r <= spec2_r;
      sval3_r <= sval2_r;
      sgn3_r  <= (sum2_r == 28'd0) ? zs2_r : sgn2_r;
      e3_r    <= 11'(e2_r) + 11'd1 - 11'(lz);
      sig3_r  <= {norm[27:3], |norm[2:0]};
    end
  end

  // stage 4: round and pack
  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= spec3_r ? sval3_r : round_pack(sgn3_r, e3_r, sig3_r);
    end
  end

  assign y = y_r;

endmodule

// ===== design/hyperconnection_post_mix_core.sv =====
// ----------------------------------------------------------------------------
// hyperconnection_post_mix_core
// Post-layer mix of four residual streams with per-token fp32 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries two kinds of
//   request. A load request (cmd 0) writes one of twenty coefficients: four
//   post weights and the 4x4 mix. It takes effect for the very next request
//   and gives no result. A column request (cmd 1) gives exactly one result
//   on the output channel (out_valid / out_ready / out_data).
//   Each target is post weight times layer plus four mix products, every
//   step a rounded fp32 operation, rounded to bf16 at the end. Any
//   non-finite input or coefficient zeroes the outputs and sets the error.
//   The datapath has 20 register stages: 3 multiply stages, four chained
//   adds of 4 stages each, and one output register stage.
//   Throughput is one request per cycle while no result is held waiting,
//   set by the fully pipelined multipliers and adders.
//   Reset clears all coefficients to zero and empties the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hyperconnection_post_mix_core
  import hpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hpm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hpm_out_t out_data
);

  logic              adv;
  logic              acc;
  logic [31:0]       coef_r [COEF_COUNT];
  logic [LATENCY-1:0] vld_r;
  hpm_tag_t          tag_r [LATENCY];
  hpm_tag_t          tag_in;
  logic              coef_bad;
  logic [15:0]       res [STREAM_COUNT];
  logic [31:0]       prod [STREAM_COUNT][STREAM_COUNT+1];
  logic [31:0]       psum [STREAM_COUNT][STREAM_COUNT+1];
  logic [31:0]       pdly [STREAM_COUNT][STREAM_COUNT];
  hpm_out_t          out_r;

  // whole pipeline moves unless a finished result is held
  assign adv      = !vld_r[LATENCY-1] || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  assign res[0] = in_data.residual_0;
  assign res[1] = in_data.residual_1;
  assign res[2] = in_data.residual_2;
  assign res[3] = in_data.residual_3;

  // coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_COUNT; i++) coef_r[i] <= 32'd0;
    end else if (acc && in_data.cmd == CMD_LOAD &&
                 in_data.coef_index < 5'(COEF_COUNT)) begin
      coef_r[in_data.coef_index] <= in_data.coef_value;
    end
  end

  // non-finite check on the request and on the stored coefficients
  always_comb begin
    coef_bad = 1'b0;
    for (int i = 0; i < COEF_COUNT; i++) begin
      if (!fp32_finite(coef_r[i])) coef_bad = 1'b1;
    end
    tag_in.last = in_data.last_column;
    tag_in.err  = coef_bad || !bf16_finite(in_data.layer_value);
    for (int s = 0; s < STREAM_COUNT; s++) begin
      if (!bf16_finite(res[s])) tag_in.err = 1'b1;
    end
  end

  // valid bits and request tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LATENCY-2:0], acc && in_data.cmd == CMD_COLUMN};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= tag_in;
      for (int i = 1; i < LATENCY; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // per target: five products, then four chained adds
  for (genvar t = 0; t < STREAM_COUNT; t++) begin : g_tgt
    hpm_fmul u_post (
      .clk (clk),
      .en  (adv),
      .a   (coef_r[t]),
      .b   (in_data.layer_value),
      .y   (prod[t][0])
    );

    for (genvar s = 0; s < STREAM_COUNT; s++) begin : g_src
      hpm_fmul u_mix (
        .clk (clk),
        .en  (adv),
        .a   (coef_r[STREAM_COUNT + s * STREAM_COUNT + t]),
        .b   (res[s]),
        .y   (prod[t][s+1])
      );
    end

    assign psum[t][0] = prod[t][0];

    for (genvar k = 0; k < STREAM_COUNT; k++) begin : g_add
      // product waits for the running sum to reach this adder
      if (k == 0) begin : g_direct
        assign pdly[t][k] = prod[t][k+1];
      end else begin : g_delay
        logic [31:0] dl_r [ADD_STAGES*k];
        always_ff @(posedge clk) begin
          if (adv) begin
            dl_r[0] <= prod[t][k+1];
            for (int i = 1; i < ADD_STAGES * k; i++) dl_r[i] <= dl_r[i-1];
          end
        end
        assign pdly[t][k] = dl_r[ADD_STAGES*k-1];
      end

      hpm_fadd u_add (
        .clk (clk),
        .en  (adv),
        .a   (psum[t][k]),
        .b   (pdly[t][k]),
        .y   (psum[t][k+1])
      );
    end
  end

  // output register: bf16 rounding and error zeroing
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_0           <= tag_r[LATENCY-2].err ? 16'd0 : to_bf16(psum[0][STREAM_COUNT]);
      out_r.out_1           <= tag_r[LATENCY-2].err ? 16'd0 : to_bf16(psum[1][STREAM_COUNT]);
      out_r.out_2           <= tag_r[LATENCY-2].err ? 16'd0 : to_bf16(psum[2][STREAM_COUNT]);
      out_r.out_3           <= tag_r[LATENCY-2].err ? 16'd0 : to_bf16(psum[3][STREAM_COUNT]);
      out_r.end_of_token    <= tag_r[LATENCY-2].last;
      out_r.nonfinite_error <= tag_r[LATENCY-2].err;
    end
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_data  = out_r;

endmodule
